// ----- rtl/key_value_tracker_table_assert.svh -----
// Assertion macros used by the key/value tracker table top level.
`ifndef KEY_VALUE_TRACKER_TABLE_ASSERT_SVH
`define KEY_VALUE_TRACKER_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KVT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("key/value table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KVT_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("key/value table assertion failed");

`endif

// ----- rtl/kvt_pkg.sv -----
// Types and codes shared by the key/value tracker table modules.
package kvt_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int LIVE_W  = 7;
    localparam int LIVE_MAX = 127;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_CLEAR  = 2'd3
    } kvt_req_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_MISS = 2'd3
    } kvt_status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_WALK,
        FSM_FIN
    } kvt_state_t;

    // Request token that walks the cell chain, gathering match and free-slot results.
    typedef struct packed {
        logic             valid;
        kvt_req_t         req;
        logic [KEY_W-1:0] key;
        logic             hit;
        logic [VAL_W-1:0] value;
        logic             free_hit;
    } kvt_tok_t;

    // Update broadcast to every cell when a request completes.
    typedef struct packed {
        logic             we;
        logic             clr;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } kvt_wr_t;

endpackage

// ----- rtl/key_value_tracker_table.sv -----
// Top level of the key/value tracker table: request control, cell chain and result register.
// Each request token enters a chain of TABLE_DEPTH slot cells and moves one cell per
// clock. When it leaves the last cell it is loaded into the result register, and the
// result goes to the m_axis output register once the output is free. The next item is
// taken only after that, so a stalled output holds back both the result and the next
// item. One item is in flight at a time; a finished result waits in the output register
// while the next item is taken. Inserts go to the lowest free slot, and live_count
// saturates at 127.
module key_value_tracker_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key[31:0], entry_value[63:32]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // status[1:0], found[2], value_out[34:3],
                                        // live_count[41:35], zero[47:42]
);
    import kvt_pkg::*;

    `include "key_value_tracker_table_assert.svh"

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CW    = (CNT_W > LIVE_W) ? CNT_W : LIVE_W;

    kvt_state_t       state_reg;
    kvt_state_t       state_next;
    kvt_tok_t         tok_head;
    kvt_tok_t         tok [0:TABLE_DEPTH];
    logic [IDX_W-1:0] fidx [0:TABLE_DEPTH];
    kvt_tok_t         res_tok_reg;
    logic [IDX_W-1:0] res_idx_reg;
    logic [VAL_W-1:0] in_val_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CW-1:0]    cnt_wide;
    kvt_wr_t          wr;
    logic             accept;
    logic             out_free;
    logic             fin_ld;
    logic             do_fin;
    logic             rm_hit;
    kvt_status_t      status;
    logic             found;
    logic [VAL_W-1:0] value_out;
    logic [LIVE_W-1:0] live;

    logic              m_tvalid_reg;
    kvt_status_t       m_status_reg;
    logic              m_found_reg;
    logic [VAL_W-1:0]  m_value_reg;
    logic [LIVE_W-1:0] m_live_reg;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_tvalid_reg || m_axis_tready;

    always_comb begin
        tok_head       = '0;
        tok_head.valid = accept;
        tok_head.req   = kvt_req_t'(s_axis_tuser[1:0]);
        tok_head.key   = s_axis_tdata[31:0];
    end

    assign tok[0]  = tok_head;
    assign fidx[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            kvt_cell #(
                .IDX_W    (IDX_W),
                .CELL_IDX (gi)
            ) u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .tok_in       (tok[gi]),
                .free_idx_in  (fidx[gi]),
                .tok_out      (tok[gi+1]),
                .free_idx_out (fidx[gi+1]),
                .wr           (wr),
                .wr_idx       (res_idx_reg)
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        fin_ld        = 1'b0;
        do_fin        = 1'b0;
        case (state_reg)
            FSM_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    state_next = FSM_WALK;
                end
            end
            FSM_WALK: begin
                if (tok[TABLE_DEPTH].valid) begin
                    fin_ld     = 1'b1;
                    state_next = FSM_FIN;
                end
            end
            FSM_FIN: begin
                if (out_free) begin
                    do_fin     = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb begin
        wr.we    = do_fin && res_tok_reg.req == REQ_INSERT && !res_tok_reg.hit
                   && res_tok_reg.free_hit;
        wr.clr   = do_fin && res_tok_reg.req == REQ_CLEAR;
        wr.key   = res_tok_reg.key;
        wr.value = in_val_reg;
        rm_hit   = do_fin && res_tok_reg.req == REQ_REMOVE && res_tok_reg.hit;

        cnt_next = cnt_reg;
        if (wr.clr) begin
            cnt_next = '0;
        end else if (wr.we) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (rm_hit) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        cnt_wide = CW'(cnt_next);
        live     = (cnt_wide > CW'(LIVE_MAX)) ? LIVE_W'(LIVE_MAX) : cnt_wide[LIVE_W-1:0];

        status    = ST_OK;
        found     = res_tok_reg.hit;
        value_out = '0;
        case (res_tok_reg.req)
            REQ_INSERT: begin
                if (res_tok_reg.hit) begin
                    status = ST_DUP;
                end else if (!res_tok_reg.free_hit) begin
                    status = ST_FULL;
                end
            end
            REQ_REMOVE: begin
                if (!res_tok_reg.hit) begin
                    status = ST_MISS;
                end
            end
            REQ_LOOKUP: begin
                if (res_tok_reg.hit) begin
                    value_out = res_tok_reg.value;
                end else begin
                    status = ST_MISS;
                end
            end
            default: begin
                found = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_fin) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_val_reg <= s_axis_tdata[63:32];
        end
        if (fin_ld) begin
            res_tok_reg <= tok[TABLE_DEPTH];
            res_idx_reg <= fidx[TABLE_DEPTH];
        end
        if (do_fin) begin
            m_status_reg <= status;
            m_found_reg  <= found;
            m_value_reg  <= value_out;
            m_live_reg   <= live;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {6'd0, m_live_reg, m_value_reg, m_found_reg, m_status_reg};

    `KVT_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(TABLE_DEPTH))
    `KVT_ASSERT_NXT(a_accept_walk, aclk, aresetn, accept, state_reg == FSM_WALK)
    `KVT_ASSERT_IMP(a_tok_in_walk, aclk, aresetn, tok[TABLE_DEPTH].valid,
                    state_reg == FSM_WALK)
    `KVT_ASSERT_IMP(a_full_count, aclk, aresetn,
                    state_reg == FSM_FIN && res_tok_reg.req == REQ_INSERT
                    && !res_tok_reg.free_hit,
                    cnt_reg == CNT_W'(TABLE_DEPTH))

endmodule

// ----- rtl/kvt_cell.sv -----
// One table slot: holds a key and value and passes the request token to the next slot.
module kvt_cell #(
    parameter int IDX_W    = 6,
    parameter int CELL_IDX = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  kvt_pkg::kvt_tok_t  tok_in,
    input  logic [IDX_W-1:0]   free_idx_in,
    output kvt_pkg::kvt_tok_t  tok_out,
    output logic [IDX_W-1:0]   free_idx_out,
    input  kvt_pkg::kvt_wr_t   wr,
    input  logic [IDX_W-1:0]   wr_idx
);
    import kvt_pkg::*;

    logic             valid_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    kvt_tok_t         tok_reg;
    kvt_tok_t         tok_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             hit_here;
    logic             sel_here;

    assign hit_here = tok_in.valid && valid_reg && (key_reg == tok_in.key)
                      && (tok_in.req != REQ_CLEAR);
    assign sel_here = wr.we && (wr_idx == IDX_W'(CELL_IDX));

    always_comb begin
        tok_next          = tok_in;
        tok_next.hit      = tok_in.hit | hit_here;
        tok_next.value    = hit_here ? value_reg : tok_in.value;
        tok_next.free_hit = tok_in.free_hit | !valid_reg;
        idx_next          = (!valid_reg && !tok_in.free_hit) ? IDX_W'(CELL_IDX) : free_idx_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            tok_reg <= tok_next;
            if (wr.clr) begin
                valid_reg <= 1'b0;
            end else if (sel_here) begin
                valid_reg <= 1'b1;
            end else if (hit_here && tok_in.req == REQ_REMOVE) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (sel_here) begin
            key_reg   <= wr.key;
            value_reg <= wr.value;
        end
    end

    assign tok_out      = tok_reg;
    assign free_idx_out = idx_reg;

endmodule

// ----- dv/key_value_tracker_table_checker.sv -----
// Checker that mirrors the key/value table, predicts each response and compares it.
module key_value_tracker_table_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key[31:0], entry_value[63:32]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // status[1:0], found[2], value_out[34:3],
                                        // live_count[41:35], zero[47:42]
    output int          error_count,
    output int          responses_seen,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import kvt_pkg::*;

    typedef struct packed {
        logic [5:0]        pad;
        logic [LIVE_W-1:0] live;
        logic [VAL_W-1:0]  value;
        logic              found;
        kvt_status_t       status;
    } kvt_resp_t;

    logic             slot_used [TABLE_DEPTH];
    logic [KEY_W-1:0] slot_key  [TABLE_DEPTH];
    logic [VAL_W-1:0] slot_val  [TABLE_DEPTH];
    int               live_entries;
    int               fail_tally = 0;
    kvt_resp_t        awaited_responses [$];

    function automatic kvt_resp_t predict_table_response(kvt_req_t req,
                                                         logic [KEY_W-1:0] key,
                                                         logic [VAL_W-1:0] val);
        kvt_resp_t r;
        int        hit;
        int        free_idx;
        r = '0;
        r.status = ST_OK;
        hit = -1;
        free_idx = -1;
        if (req == REQ_CLEAR) begin
            for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
            live_entries = 0;
        end else begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (hit < 0 && slot_used[i] && slot_key[i] == key) hit = i;
            case (req)
                REQ_INSERT: begin
                    if (hit >= 0) begin
                        r.status = ST_DUP;
                        r.found = 1'b1;
                    end else begin
                        for (int i = 0; i < TABLE_DEPTH; i++)
                            if (free_idx < 0 && !slot_used[i]) free_idx = i;
                        if (free_idx < 0) begin
                            r.status = ST_FULL;
                        end else begin
                            slot_used[free_idx] = 1'b1;
                            slot_key[free_idx] = key;
                            slot_val[free_idx] = val;
                            live_entries++;
                        end
                    end
                end
                REQ_REMOVE: begin
                    if (hit >= 0) begin
                        r.found = 1'b1;
                        slot_used[hit] = 1'b0;
                        if (live_entries > 0) live_entries--;
                    end else begin
                        r.status = ST_MISS;
                    end
                end
                default: begin
                    if (hit >= 0) begin
                        r.found = 1'b1;
                        r.value = slot_val[hit];
                    end else begin
                        r.status = ST_MISS;
                    end
                end
            endcase
        end
        r.live = (live_entries > LIVE_MAX) ? LIVE_W'(LIVE_MAX) : LIVE_W'(live_entries);
        return r;
    endfunction

    always @(posedge aclk) begin
        kvt_resp_t want;
        kvt_resp_t got;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
            live_entries = 0;
            awaited_responses.delete();
            responses_seen <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                awaited_responses.push_back(predict_table_response(
                    kvt_req_t'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[63:32]));
            if (m_axis_tvalid && m_axis_tready) begin
                got = kvt_resp_t'(m_axis_tdata);
                responses_seen <= responses_seen + 1;
                if (awaited_responses.size() == 0) begin
                    $display("%0t: unexpected response, expected none, got %h", $time,
                             m_axis_tdata);
                    fail_tally++;
                end else begin
                    want = awaited_responses.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d", $time,
                                 want.status, got.status);
                        fail_tally++;
                    end
                    if (got.found !== want.found) begin
                        $display("%0t: found expected %0d, got %0d", $time,
                                 want.found, got.found);
                        fail_tally++;
                    end
                    if (got.value !== want.value) begin
                        $display("%0t: value_out expected %h, got %h", $time,
                                 want.value, got.value);
                        fail_tally++;
                    end
                    if (got.live !== want.live) begin
                        $display("%0t: live_count expected %0d, got %0d", $time,
                                 want.live, got.live);
                        fail_tally++;
                    end
                    if (got.pad !== want.pad) begin
                        $display("%0t: padding expected %h, got %h", $time,
                                 want.pad, got.pad);
                        fail_tally++;
                    end
                end
            end
        end
        error_count <= fail_tally;
        pending_count <= awaited_responses.size();
    end

endmodule

// ----- dv/key_value_tracker_table_tb.sv -----
// Testbench top for the key/value tracker table: clock, reset, requests and verdict.
module key_value_tracker_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kvt_pkg::*;

    localparam int TABLE_DEPTH     = 64;
    localparam int KEY_POOL_N      = 72;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int FILL_ITEMS      = 110;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // key[31:0], entry_value[63:32]
    logic [1:0]  s_axis_tuser;   // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // status[1:0], found[2], value_out[34:3],
                                 // live_count[41:35], zero[47:42]

    int          error_count;
    int          responses_seen;
    int          pending_count;
    int          items_sent = 0;
    int          fill_cursor = 0;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          src_pcts [4] = '{0, 87, 0, 26};
    int          snk_pcts [4] = '{0, 0, 87, 26};
    logic [31:0] key_pool [KEY_POOL_N];

    key_value_tracker_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    key_value_tracker_table_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .error_count   (error_count),
        .responses_seen(responses_seen),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic issue_request(kvt_req_t req, logic [31:0] key, logic [31:0] val);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {val, key};
        s_axis_tuser <= req;
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
    endtask

    // While filling, inserts walk the key pool in order so the table reaches full.
    task automatic random_request(bit filling);
        int          roll;
        logic [31:0] key;
        kvt_req_t    req;
        roll = $urandom_range(99);
        key = ($urandom_range(99) < 15) ? $urandom : key_pool[$urandom_range(KEY_POOL_N-1)];
        if (filling) begin
            if (roll < 80) begin
                req = REQ_INSERT;
                key = key_pool[fill_cursor];
                fill_cursor = (fill_cursor + 1) % KEY_POOL_N;
            end else if (roll < 90) begin
                req = REQ_LOOKUP;
            end else begin
                req = REQ_REMOVE;
            end
        end else begin
            if (roll < 60) req = REQ_REMOVE;
            else if (roll < 85) req = REQ_LOOKUP;
            else if (roll < 99) req = REQ_INSERT;
            else req = REQ_CLEAR;
        end
        issue_request(req, key, $urandom);
    endtask

    initial begin
        aresetn <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= REQ_INSERT;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < KEY_POOL_N; i++) key_pool[i] = $urandom;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        issue_request(REQ_INSERT, 32'h0000_0000, 32'h0000_0000);
        issue_request(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_request(REQ_LOOKUP, 32'h0000_0000, 32'h1234_5678);
        issue_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        issue_request(REQ_INSERT, 32'h0000_0000, 32'hDEAD_BEEF);
        issue_request(REQ_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        issue_request(REQ_REMOVE, 32'h0000_0000, 32'h0000_0000);
        issue_request(REQ_REMOVE, 32'h0000_0000, 32'h0000_0000);
        issue_request(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        issue_request(REQ_LOOKUP, 32'h0000_0001, 32'h0000_0000);
        issue_request(REQ_INSERT, 32'h8000_0000, 32'h5A5A_5A5A);
        issue_request(REQ_INSERT, 32'h0000_0000, 32'h0000_0001);
        issue_request(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        issue_request(REQ_LOOKUP, 32'h8000_0000, 32'h0000_0000);
        issue_request(REQ_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        issue_request(REQ_REMOVE, 32'h8000_0000, 32'h0000_0000);
        issue_request(REQ_CLEAR,  32'h0000_0000, 32'h0000_0000);
        issue_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        issue_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'hA5A5_A5A5);

        for (int phase = 0; phase < 4; phase++) begin
            src_idle_pct = src_pcts[phase];
            snk_stall_pct = snk_pcts[phase];
            for (int j = 0; j < ITEMS_PER_PHASE; j++) random_request(j < FILL_ITEMS);
        end
        s_axis_tvalid <= 1'b0;

        while (responses_seen != items_sent) @(posedge aclk);
        repeat (TABLE_DEPTH + 8) @(posedge aclk);
        if (error_count == 0 && pending_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/kvt_pkg.sv
rtl/kvt_cell.sv
rtl/key_value_tracker_table.sv
dv/key_value_tracker_table_checker.sv
dv/key_value_tracker_table_tb.sv
